// ===== src/bdlp_pkg.sv =====
// types and constants shared by the button debouncer files
package bdlp_pkg;

  // stable status doubles as the event code sent out
  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_LONG    = 2'd2,
    EV_REPEAT  = 2'd3
  } event_t;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS    = 3'd1;
  localparam logic [2:0] REG_REPEAT_START  = 3'd2;
  localparam logic [2:0] REG_REPEAT_PERIOD = 3'd3;
  localparam logic [2:0] REG_REPEAT_ENABLE = 3'd4;

  localparam logic [CountWidth-1:0] DebounceReset     = 8'd3;
  localparam logic [CountWidth-1:0] LongPressReset    = 8'd50;
  localparam logic [CountWidth-1:0] RepeatStartReset  = 8'd75;
  localparam logic [CountWidth-1:0] RepeatPeriodReset = 8'd10;
  localparam logic                  RepeatEnableReset = 1'b1;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef struct packed {
    logic [CountWidth-1:0] debounce_ticks;
    logic [CountWidth-1:0] long_press_ticks;
    logic [CountWidth-1:0] repeat_start_ticks;
    logic [CountWidth-1:0] repeat_period_ticks;
    logic                  repeat_enable;
  } cfg_t;

endpackage

// ===== src/bdlp_in_if.sv =====
// pin sample channel
interface bdlp_in_if;
  logic valid;
  logic ready;
  logic raw_pin;

  modport source (output valid, output raw_pin, input ready);
  modport sink (input valid, input raw_pin, output ready);
endinterface

// ===== src/bdlp_out_if.sv =====
// button event channel
interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] button_event;

  modport source (output valid, output button_event, input ready);
  modport sink (input valid, input button_event, output ready);
endinterface

// ===== src/bdlp_regs.sv =====
// apb configuration registers of the button debouncer
module bdlp_regs
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[AddrWidth-1:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= DebounceReset;
      cfg.long_press_ticks    <= LongPressReset;
      cfg.repeat_start_ticks  <= RepeatStartReset;
      cfg.repeat_period_ticks <= RepeatPeriodReset;
      cfg.repeat_enable       <= RepeatEnableReset;
    end else if (wr_en) begin
      case (reg_index)
        REG_DEBOUNCE:      cfg.debounce_ticks      <= pwdata[CountWidth-1:0];
        REG_LONG_PRESS:    cfg.long_press_ticks    <= pwdata[CountWidth-1:0];
        REG_REPEAT_START:  cfg.repeat_start_ticks  <= pwdata[CountWidth-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period_ticks <= pwdata[CountWidth-1:0];
        REG_REPEAT_ENABLE: cfg.repeat_enable       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_DEBOUNCE:      prdata = {{(DataWidth-CountWidth){1'b0}}, cfg.debounce_ticks};
      REG_LONG_PRESS:    prdata = {{(DataWidth-CountWidth){1'b0}}, cfg.long_press_ticks};
      REG_REPEAT_START:  prdata = {{(DataWidth-CountWidth){1'b0}}, cfg.repeat_start_ticks};
      REG_REPEAT_PERIOD: prdata = {{(DataWidth-CountWidth){1'b0}}, cfg.repeat_period_ticks};
      REG_REPEAT_ENABLE: prdata = {{(DataWidth-1){1'b0}}, cfg.repeat_enable};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/button_debounce_long_press_repeat.sv =====
// button debouncer with long press and auto-repeat, top level
// an event is shown in the cycle after the sample transaction that causes it
// throughput: one sample per cycle unless stalled; the status/counter update is combinational logic
// the output register stalls the input only while an event waits and out ready is low
// reset (synchronous, active high): status release, level not pressed, counter 0,
// registers back to 3, 50, 75, 10 and repeat enabled, no event pending
module button_debounce_long_press_repeat
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  bdlp_in_if.sink              in_ch,
  bdlp_out_if.source           out_ch,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t cfg;

  bdlp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // debouncer state
  event_t                stable_status;
  event_t                stable_status_next;
  logic                  last_level;
  logic                  last_level_next;
  logic [CountWidth-1:0] tick_count;
  logic [CountWidth-1:0] tick_count_next;
  logic                  emit;

  // output register
  logic                  out_valid;
  event_t                out_event;

  logic                  accept;
  logic                  level;
  logic [CountWidth:0]   repeat_due;

  // pin is active low, level 1 means pressed
  assign level      = ~in_ch.raw_pin;
  // sum kept one bit wider so an out of range target is never reached
  assign repeat_due = {1'b0, cfg.repeat_start_ticks} + {1'b0, cfg.repeat_period_ticks};

  // a new sample enters whenever the output register is free or being drained
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    stable_status_next = stable_status;
    last_level_next    = last_level;
    tick_count_next    = tick_count;
    emit               = 1'b0;

    // level change restarts the count, otherwise count with saturation while pressed or not in release
    if (level == last_level) begin
      if ((level || stable_status != EV_RELEASE) && tick_count != CountMax) begin
        tick_count_next = tick_count + 1'b1;
      end
    end else begin
      tick_count_next = '0;
      last_level_next = level;
    end

    // evaluate only once the level has been stable long enough
    if (tick_count_next >= cfg.debounce_ticks) begin
      if (last_level_next) begin
        case (stable_status)
          EV_RELEASE: begin
            stable_status_next = EV_PRESS;
            emit               = 1'b1;
          end
          EV_PRESS: begin
            if (tick_count_next >= cfg.long_press_ticks) begin
              stable_status_next = EV_LONG;
              emit               = 1'b1;
            end
          end
          EV_LONG: begin
            if (cfg.repeat_enable && tick_count_next >= cfg.repeat_start_ticks) begin
              stable_status_next = EV_REPEAT;
              emit               = 1'b1;
            end
          end
          EV_REPEAT: begin
            // each repeat reloads the counter to the repeat start point
            if (cfg.repeat_enable && {1'b0, tick_count_next} >= repeat_due) begin
              tick_count_next = cfg.repeat_start_ticks;
              emit            = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        // stable release
        stable_status_next = EV_RELEASE;
        tick_count_next    = '0;
        emit               = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_status <= EV_RELEASE;
      last_level    <= 1'b0;
      tick_count    <= '0;
    end else if (accept) begin
      stable_status <= stable_status_next;
      last_level    <= last_level_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // event code is the status after the update
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_event <= stable_status_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.button_event = out_event;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the button debouncer with long press and auto-repeat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdlp_pkg::*;

  // first register index past the end of the map, writes there must be ignored
  localparam logic [2:0] RegSpareFirst = REG_REPEAT_ENABLE + 3'd1;

  localparam int unsigned HeavyIdlePct = 84;
  localparam int unsigned LightIdlePct = 30;
  localparam int unsigned PrintedMismatchMax = 40;
  // idle cycles after the last event; the block answers in the cycle after it accepts a sample
  localparam int unsigned SettleCycles = 4;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // tracks debouncer state and the events it has to send, in order
  class debounce_scoreboard;
    cfg_t                  cfg;
    event_t                status;
    logic                  pressed_last;
    logic [CountWidth-1:0] ticks;
    event_t                expected_events[$];
    int unsigned           mismatches;
    int unsigned           samples;
    int unsigned           events_seen;
    int unsigned           per_kind[4];

    function new();
      cfg.debounce_ticks      = DebounceReset;
      cfg.long_press_ticks    = LongPressReset;
      cfg.repeat_start_ticks  = RepeatStartReset;
      cfg.repeat_period_ticks = RepeatPeriodReset;
      cfg.repeat_enable       = RepeatEnableReset;
      status       = EV_RELEASE;
      pressed_last = 1'b0;
      ticks        = '0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PrintedMismatchMax) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void set_register(logic [2:0] idx, logic [DataWidth-1:0] data);
      case (idx)
        REG_DEBOUNCE:      cfg.debounce_ticks      = data[CountWidth-1:0];
        REG_LONG_PRESS:    cfg.long_press_ticks    = data[CountWidth-1:0];
        REG_REPEAT_START:  cfg.repeat_start_ticks  = data[CountWidth-1:0];
        REG_REPEAT_PERIOD: cfg.repeat_period_ticks = data[CountWidth-1:0];
        REG_REPEAT_ENABLE: cfg.repeat_enable       = data[0];
        default: ;
      endcase
    endfunction

    function logic [DataWidth-1:0] register_value(logic [2:0] idx);
      case (idx)
        REG_DEBOUNCE:      return DataWidth'(cfg.debounce_ticks);
        REG_LONG_PRESS:    return DataWidth'(cfg.long_press_ticks);
        REG_REPEAT_START:  return DataWidth'(cfg.repeat_start_ticks);
        REG_REPEAT_PERIOD: return DataWidth'(cfg.repeat_period_ticks);
        REG_REPEAT_ENABLE: return DataWidth'(cfg.repeat_enable);
        default:           return '0;
      endcase
    endfunction

    // one pin sample: update level, counter and status, queue the event if any
    function void note_sample(logic raw_pin);
      logic       pressed;
      logic       emit;
      logic [8:0] repeat_due;
      pressed = !raw_pin;
      emit    = 1'b0;
      samples++;
      if (pressed == pressed_last) begin
        if (pressed || status != EV_RELEASE) begin
          if (ticks != CountMax) ticks = ticks + 1'b1;
        end
      end else begin
        ticks        = '0;
        pressed_last = pressed;
      end
      if (ticks >= cfg.debounce_ticks) begin
        if (pressed_last) begin
          case (status)
            EV_RELEASE: begin
              status = EV_PRESS;
              emit   = 1'b1;
            end
            EV_PRESS: begin
              if (ticks >= cfg.long_press_ticks) begin
                status = EV_LONG;
                emit   = 1'b1;
              end
            end
            EV_LONG: begin
              if (cfg.repeat_enable && ticks >= cfg.repeat_start_ticks) begin
                status = EV_REPEAT;
                emit   = 1'b1;
              end
            end
            default: begin
              // sum kept at 9 bits so a total past 255 is never reached
              repeat_due = {1'b0, cfg.repeat_start_ticks} + {1'b0, cfg.repeat_period_ticks};
              if (cfg.repeat_enable && {1'b0, ticks} >= repeat_due) begin
                ticks = cfg.repeat_start_ticks;
                emit  = 1'b1;
              end
            end
          endcase
        end else begin
          status = EV_RELEASE;
          ticks  = '0;
          emit   = 1'b1;
        end
      end
      if (emit) expected_events.push_back(status);
    endfunction

    task check_event(event_t got);
      event_t want;
      events_seen++;
      if (!$isunknown(got)) per_kind[got]++;
      if (expected_events.size() == 0) begin
        report($sformatf("event %0d (%s) with none expected", got, got.name()));
        return;
      end
      want = expected_events.pop_front();
      if (got !== want)
        report($sformatf("button_event %0d (%s), expected %0d (%s)",
                         got, got.name(), want, want.name()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();

  debounce_scoreboard sb = new();

  // idle and stall percentages in force, changed by the stimulus as it goes
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  idle_mode_t  idle_mode     = IDLE_NONE;
  int unsigned settings_applied = 0;

  button_debounce_long_press_repeat u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // receiver side: ready drops at random according to the current stall rate
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // sample both channels at the edge, samples feed the predictor, events get checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.raw_pin);
      if (out_ch.valid && out_ch.ready) sb.check_event(event_t'(out_ch.button_event));
    end
  end

  // hard stop in case the block hangs a handshake
  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = HeavyIdlePct;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = HeavyIdlePct;
      end
      default: begin
        send_idle_pct = LightIdlePct;
        stall_pct     = LightIdlePct;
      end
    endcase
  endtask

  // apb write: setup phase, access phase, then the bus is released
  task automatic reg_write(logic [2:0] idx, logic [DataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_read(logic [2:0] idx, output logic [DataWidth-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back every real register and compare with the predicted contents
  task automatic check_registers();
    logic [DataWidth-1:0] got;
    logic [2:0]           idx;
    for (int i = REG_DEBOUNCE; i <= REG_REPEAT_ENABLE; i++) begin
      idx = 3'(i);
      reg_read(idx, got);
      if (got !== sb.register_value(idx))
        sb.report($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                            idx, got, sb.register_value(idx)));
    end
  endtask

  // full register set with junk in the unused upper bits, plus a write off the map, then a readback
  task automatic apply_setting(logic [7:0] debounce, logic [7:0] long_press,
                               logic [7:0] rep_start, logic [7:0] rep_period,
                               logic rep_enable);
    reg_write(REG_DEBOUNCE,      ($urandom() & ~32'hFF) | debounce);
    reg_write(REG_LONG_PRESS,    ($urandom() & ~32'hFF) | long_press);
    reg_write(REG_REPEAT_START,  ($urandom() & ~32'hFF) | rep_start);
    reg_write(REG_REPEAT_PERIOD, ($urandom() & ~32'hFF) | rep_period);
    reg_write(REG_REPEAT_ENABLE, ($urandom() & ~32'h1) | rep_enable);
    reg_write(RegSpareFirst + 3'($urandom_range(0, 2)), $urandom());
    check_registers();
    settings_applied++;
  endtask

  // one pin sample transaction, with random idle cycles in front of it
  task automatic send_sample(logic pin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.raw_pin <= pin;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_run(logic pin, int unsigned count);
    repeat (count) send_sample(pin);
  endtask

  // wait for every predicted event, then let the output register settle
  task automatic drain();
    @(posedge clk);
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // length of one steady stretch, scaled to the delays now programmed
  function automatic int unsigned hold_len(bit pressed);
    int unsigned deb;
    int unsigned reach;
    deb = sb.cfg.debounce_ticks;
    if (pressed) begin
      reach = (sb.cfg.long_press_ticks > sb.cfg.repeat_start_ticks) ?
              sb.cfg.long_press_ticks : sb.cfg.repeat_start_ticks;
      reach = reach + 3 * sb.cfg.repeat_period_ticks;
    end else begin
      reach = deb + 4;
    end
    if (reach < deb + 1) reach = deb + 1;
    if (reach > 300) reach = 300;
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(1, deb + 1);           // too short to debounce, mostly
      9:    return pressed ? $urandom_range(256, 300)    // long enough to saturate the counter
                           : $urandom_range(deb + 1, deb + 8);
      default: return $urandom_range(deb + 1, reach);
    endcase
  endfunction

  // press and release stretches with bounce bursts, idling mix rotates every 100 samples
  task automatic random_phase(int unsigned count);
    int unsigned sent;
    int unsigned chunk;
    int unsigned len;
    bit          pressed;
    sent    = 0;
    chunk   = 0;
    pressed = 1'($urandom_range(0, 1));
    while (sent < count) begin
      if (sent / 100 != chunk) begin
        chunk     = sent / 100;
        idle_mode = idle_mode.next();
        set_idling(idle_mode);
      end
      // now and then hold off until every pending event is out
      if ($urandom_range(0, 24) == 0) begin
        in_ch.valid <= 1'b0;
        drain();
      end
      // contact bounce
      if ($urandom_range(0, 9) < 3) begin
        len = $urandom_range(1, 4);
        repeat (len) send_sample(1'($urandom_range(0, 1)));
        sent += len;
      end
      // mostly alternate, sometimes the same level again
      if ($urandom_range(0, 4) != 0) pressed = !pressed;
      len = hold_len(pressed);
      // keep the phase close to its sample budget
      if (sent >= count) len = 0;
      else if (len > count - sent) len = count - sent;
      send_run(!pressed, len);
      sent += len;
    end
    in_ch.valid <= 1'b0;
    drain();
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.raw_pin <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values must read back before anything is written
    check_registers();

    // directed: short delays so press, long press, repeats and release all show up
    set_idling(IDLE_NONE);
    apply_setting(8'd1, 8'd3, 8'd5, 8'd2, 1'b1);
    send_run(1'b1, 2);
    send_run(1'b0, 12);
    // sender holds off until all events are out
    in_ch.valid <= 1'b0;
    drain();
    send_run(1'b1, 3);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);
    send_sample(1'b1);
    send_run(1'b1, 2);
    in_ch.valid <= 1'b0;
    drain();

    // reset delays
    apply_setting(DebounceReset, LongPressReset, RepeatStartReset, RepeatPeriodReset,
                  RepeatEnableReset);
    random_phase(220);

    // fast delays
    apply_setting(8'd1, 8'd4, 8'd8, 8'd3, 1'b1);
    random_phase(130);

    // repeat turned off while repeating, then back on during a long press
    set_idling(IDLE_BOTH);
    send_run(1'b0, 20);
    in_ch.valid <= 1'b0;
    drain();
    reg_write(REG_REPEAT_ENABLE, '0);
    send_run(1'b0, 12);
    send_run(1'b1, 4);
    send_run(1'b0, 30);
    in_ch.valid <= 1'b0;
    drain();
    reg_write(REG_REPEAT_ENABLE, 32'd1);
    send_run(1'b0, 10);
    send_run(1'b1, 5);
    in_ch.valid <= 1'b0;
    drain();

    // every delay at full scale, repeat sum out of reach
    apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    random_phase(500);

    // every delay zero, an event on every sample
    apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    random_phase(80);

    // first repeat reachable, later ones not
    apply_setting(8'd2, 8'd10, 8'd200, 8'd100, 1'b1);
    random_phase(320);

    // repeat disabled, held presses stay in long press
    apply_setting(8'd5, 8'd20, 8'd30, 8'd8, 1'b0);
    random_phase(100);

    if (sb.expected_events.size() != 0)
      sb.report($sformatf("%0d events never arrived", sb.expected_events.size()));

    $display("covered %0d pin samples over %0d register settings and four idling mixes",
             sb.samples, settings_applied);
    $display("checked %0d events: %0d release, %0d press, %0d long press, %0d repeat",
             sb.events_seen, sb.per_kind[EV_RELEASE], sb.per_kind[EV_PRESS],
             sb.per_kind[EV_LONG], sb.per_kind[EV_REPEAT]);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== button_debounce_long_press_repeat.f =====
src/bdlp_pkg.sv
src/bdlp_in_if.sv
src/bdlp_out_if.sv
src/bdlp_regs.sv
src/button_debounce_long_press_repeat.sv
tb/testbench.sv
